/* rtl/catmull_rom_point_eval_defines.svh */
// catmull_rom_point_eval_defines.svh
// Assertion macros for the spline evaluator RTL; no dependencies.
`ifndef CATMULL_ROM_POINT_EVAL_DEFINES_SVH
`define CATMULL_ROM_POINT_EVAL_DEFINES_SVH

// same-cycle implication
`define CRPE_ASSERT_COMB(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRPE_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/crpe_pkg.sv */
// crpe_pkg.sv
// Shared constants and types of the Catmull-Rom point evaluator.
// No dependencies.
package crpe_pkg;

    localparam int DEF_MAX_NODES      = 64;
    localparam int DEF_COORD_BITS     = 24;
    localparam int DEF_TIME_FRAC_BITS = 16;

    // smallest usable node count, also the window of nodes per section
    localparam int MIN_NODES     = 4;
    localparam int SPAN          = 4;
    localparam int BANK_SEL_BITS = 2;

    localparam int PIPE_STAGES = 9;
    localparam int LANE_STAGES = 6;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_t;

endpackage

/* rtl/crpe_front.sv */
// crpe_front.sv
// Input stage and section/fraction stage; holds the node_count register.
// Depends on crpe_pkg.
module crpe_front
    import crpe_pkg::*;
#(
    parameter int MAX_NODES      = DEF_MAX_NODES,
    parameter int COORD_BITS     = DEF_COORD_BITS,
    parameter int TIME_FRAC_BITS = DEF_TIME_FRAC_BITS,
    localparam int IDX_BITS      = $clog2(MAX_NODES),
    localparam int CNT_BITS      = $clog2(MAX_NODES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CNT_BITS-1:0]           cfg_wr_data,
    input  logic                          load_s1,
    input  logic                          load_s2,
    input  cmd_t                          in_cmd,
    input  logic [IDX_BITS-1:0]           in_node_index,
    input  logic [3*COORD_BITS-1:0]       in_node,
    input  logic [TIME_FRAC_BITS:0]       in_curve_time,
    output cmd_t                          s2_cmd,
    output logic [IDX_BITS-1:0]           s2_node_index,
    output logic [3*COORD_BITS-1:0]       s2_node,
    output logic [IDX_BITS-1:0]           s2_section,
    output logic [TIME_FRAC_BITS:0]       s2_frac
);

    localparam int TS_BITS = TIME_FRAC_BITS + 1 + CNT_BITS;
    localparam logic [TIME_FRAC_BITS:0] ONE_T = {1'b1, {TIME_FRAC_BITS{1'b0}}};

    logic [CNT_BITS-1:0]       node_count_reg;
    logic [CNT_BITS-1:0]       cnt_use;
    logic [CNT_BITS-1:0]       sections;
    logic [CNT_BITS-1:0]       sec_last;
    logic [TS_BITS-1:0]        ts;
    logic [CNT_BITS:0]         ts_int;
    logic [CNT_BITS-1:0]       sec;
    logic [TS_BITS-1:0]        frac_full;

    cmd_t                      s1_cmd_reg;
    logic [IDX_BITS-1:0]       s1_node_index_reg;
    logic [3*COORD_BITS-1:0]   s1_node_reg;
    logic [TIME_FRAC_BITS:0]   s1_time_reg;
    logic [TIME_FRAC_BITS:0]   s1_time_next;

    cmd_t                      s2_cmd_reg;
    logic [IDX_BITS-1:0]       s2_node_index_reg;
    logic [3*COORD_BITS-1:0]   s2_node_reg;
    logic [IDX_BITS-1:0]       s2_section_reg;
    logic [TIME_FRAC_BITS:0]   s2_frac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_BITS'(MIN_NODES);
        end
        else if (cfg_wr_en)
        begin
            node_count_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (node_count_reg < CNT_BITS'(MIN_NODES))
        begin
            cnt_use = CNT_BITS'(MIN_NODES);
        end
        else if (node_count_reg > CNT_BITS'(MAX_NODES))
        begin
            cnt_use = CNT_BITS'(MAX_NODES);
        end
        else
        begin
            cnt_use = node_count_reg;
        end
        sections = cnt_use - CNT_BITS'(MIN_NODES - 1);
        sec_last = sections - CNT_BITS'(1);
    end

    assign s1_time_next = (in_curve_time > ONE_T) ? ONE_T : in_curve_time;

    // section index and fraction; t = 1.0 lands in the last section with u = 1.0
    always_comb
    begin
        ts     = TS_BITS'(s1_time_reg) * TS_BITS'(sections);
        ts_int = ts[TS_BITS-1:TIME_FRAC_BITS];
        if (ts_int > {1'b0, sec_last})
        begin
            sec = sec_last;
        end
        else
        begin
            sec = ts_int[CNT_BITS-1:0];
        end
        frac_full = ts - (TS_BITS'(sec) << TIME_FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_cmd_reg        <= in_cmd;
            s1_node_index_reg <= in_node_index;
            s1_node_reg       <= in_node;
            s1_time_reg       <= s1_time_next;
        end
        if (load_s2)
        begin
            s2_cmd_reg        <= s1_cmd_reg;
            s2_node_index_reg <= s1_node_index_reg;
            s2_node_reg       <= s1_node_reg;
            s2_section_reg    <= IDX_BITS'(sec);
            s2_frac_reg       <= frac_full[TIME_FRAC_BITS:0];
        end
    end

    assign s2_cmd        = s2_cmd_reg;
    assign s2_node_index = s2_node_index_reg;
    assign s2_node       = s2_node_reg;
    assign s2_section    = s2_section_reg;
    assign s2_frac       = s2_frac_reg;

endmodule

/* rtl/crpe_node_mem.sv */
// crpe_node_mem.sv
// Node table in four banks by index mod 4; one read per bank gives a section's window.
// Depends on crpe_pkg.
module crpe_node_mem
    import crpe_pkg::*;
#(
    parameter int MAX_NODES      = DEF_MAX_NODES,
    parameter int COORD_BITS     = DEF_COORD_BITS,
    parameter int TIME_FRAC_BITS = DEF_TIME_FRAC_BITS,
    localparam int IDX_BITS      = $clog2(MAX_NODES),
    localparam int NODE_BITS     = 3 * COORD_BITS
) (
    input  logic                        clk,
    input  logic                        load,
    input  logic                        s2_valid,
    input  cmd_t                        s2_cmd,
    input  logic [IDX_BITS-1:0]         s2_node_index,
    input  logic [NODE_BITS-1:0]        s2_node,
    input  logic [IDX_BITS-1:0]         s2_section,
    input  logic [TIME_FRAC_BITS:0]     s2_frac,
    output logic [SPAN*NODE_BITS-1:0]   node_win,
    output logic [TIME_FRAC_BITS:0]     s3_frac
);

    localparam int BANK_DEPTH = (MAX_NODES + SPAN - 1) / SPAN;
    localparam int ROW_BITS   = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic [NODE_BITS-1:0]        rd_data_reg [SPAN];
    logic [BANK_SEL_BITS-1:0]    s3_rot_reg;
    logic [TIME_FRAC_BITS:0]     s3_frac_reg;
    logic [2*SPAN*NODE_BITS-1:0] rd_bus2;
    logic                        wr_ok;

    // slots past the table are dropped
    assign wr_ok = load && s2_valid && (s2_cmd == CMD_WRITE)
                   && ({1'b0, s2_node_index} < (IDX_BITS + 1)'(MAX_NODES));

    for (genvar b = 0; b < SPAN; b++)
    begin : g_bank
        logic [NODE_BITS-1:0]     mem [BANK_DEPTH];
        logic [BANK_SEL_BITS-1:0] offset;
        logic [IDX_BITS-1:0]      rd_node;
        logic [ROW_BITS-1:0]      rd_row;
        logic [ROW_BITS-1:0]      wr_row;
        logic                     wr_hit;

        always_comb
        begin
            offset  = BANK_SEL_BITS'(b) - s2_section[BANK_SEL_BITS-1:0];
            rd_node = s2_section + IDX_BITS'(offset);
            rd_row  = ROW_BITS'(rd_node >> BANK_SEL_BITS);
            wr_row  = ROW_BITS'(s2_node_index >> BANK_SEL_BITS);
            wr_hit  = wr_ok && (s2_node_index[BANK_SEL_BITS-1:0] == BANK_SEL_BITS'(b));
        end

        always_ff @(posedge clk)
        begin
            if (wr_hit)
            begin
                mem[wr_row] <= s2_node;
            end
            if (load)
            begin
                rd_data_reg[b] <= mem[rd_row];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s3_rot_reg  <= s2_section[BANK_SEL_BITS-1:0];
            s3_frac_reg <= s2_frac;
        end
    end

    // rotate banks so that node k comes first
    always_comb
    begin
        for (int j = 0; j < SPAN; j++)
        begin
            rd_bus2[j*NODE_BITS +: NODE_BITS]          = rd_data_reg[j];
            rd_bus2[(j+SPAN)*NODE_BITS +: NODE_BITS]   = rd_data_reg[j];
        end
        for (int j = 0; j < SPAN; j++)
        begin
            node_win[j*NODE_BITS +: NODE_BITS] =
                rd_bus2[(j + int'(s3_rot_reg))*NODE_BITS +: NODE_BITS];
        end
    end

    assign s3_frac = s3_frac_reg;

endmodule

/* rtl/crpe_lane.sv */
// crpe_lane.sv
// One coordinate of the cubic blend: coefficients, Horner steps, rounding, saturation.
// Depends on crpe_pkg.
module crpe_lane
    import crpe_pkg::*;
#(
    parameter int COORD_BITS     = DEF_COORD_BITS,
    parameter int TIME_FRAC_BITS = DEF_TIME_FRAC_BITS
) (
    input  logic                         clk,
    input  logic [LANE_STAGES-1:0]       load,
    input  logic signed [COORD_BITS-1:0] node_a,
    input  logic signed [COORD_BITS-1:0] node_b,
    input  logic signed [COORD_BITS-1:0] node_c,
    input  logic signed [COORD_BITS-1:0] node_d,
    input  logic [TIME_FRAC_BITS:0]      frac,
    output logic signed [COORD_BITS-1:0] point
);

    localparam int C      = COORD_BITS;
    localparam int F      = TIME_FRAC_BITS;
    localparam int U_W    = F + 2;
    localparam int K3_W   = C + 3;
    localparam int K2_W   = C + 4;
    localparam int K1_W   = C + 1;
    localparam int ACC1_W = K3_W + U_W;
    localparam int ACC2_W = ACC1_W + U_W;
    localparam int HI_W   = ACC2_W - F;
    localparam int H_W    = HI_W + U_W;
    localparam int R_W    = H_W - (2 * F + 1);

    localparam logic signed [H_W-1:0] HALF  = H_W'(1) << (2 * F);
    localparam logic signed [R_W-1:0] R_MAX = {{(R_W - C + 1){1'b0}}, {(C - 1){1'b1}}};
    localparam logic signed [R_W-1:0] R_MIN = {{(R_W - C + 1){1'b1}}, {(C - 1){1'b0}}};

    // stage 4: blend coefficients
    logic signed [K3_W-1:0] a3, b3, c3, d3, k3;
    logic signed [K2_W-1:0] a2, b2, c2, d2, k2;
    logic signed [K1_W-1:0] k1;
    logic signed [K3_W-1:0] s4_k3_reg;
    logic signed [K2_W-1:0] s4_k2_reg;
    logic signed [K1_W-1:0] s4_k1_reg;
    logic signed [C-1:0]    s4_b_reg;
    logic [F:0]             s4_u_reg;

    // stage 5: first Horner step
    logic signed [U_W-1:0]    su4;
    logic signed [ACC1_W-1:0] p1, acc1;
    logic signed [ACC1_W-1:0] s5_acc1_reg;
    logic signed [K1_W-1:0]   s5_k1_reg;
    logic signed [C-1:0]      s5_b_reg;
    logic [F:0]               s5_u_reg;

    // stage 6: second Horner step
    logic signed [U_W-1:0]    su5;
    logic signed [ACC2_W-1:0] p2, acc2;
    logic signed [ACC2_W-1:0] s6_acc2_reg;
    logic signed [C-1:0]      s6_b_reg;
    logic [F:0]               s6_u_reg;

    // stage 7: split at the Q16 point and scale both halves by u
    logic signed [U_W-1:0]  su6;
    logic signed [HI_W-1:0] hi;
    logic [F-1:0]           lo;
    logic signed [H_W-1:0]  p_hi;
    logic [2*F:0]           p_lo;
    logic signed [H_W-1:0]  s7_phi_reg;
    logic [F:0]             s7_plo_reg;
    logic signed [C-1:0]    s7_b_reg;

    // stage 8: sum, stage 9: round and saturate
    logic signed [H_W-1:0]  h;
    logic signed [H_W-1:0]  s8_h_reg;
    logic signed [H_W-1:0]  h_rnd;
    logic signed [R_W-1:0]  r;
    logic signed [C-1:0]    r_sat;
    logic signed [C-1:0]    s9_point_reg;

    always_comb
    begin
        a3 = K3_W'(node_a);
        b3 = K3_W'(node_b);
        c3 = K3_W'(node_c);
        d3 = K3_W'(node_d);
        a2 = K2_W'(node_a);
        b2 = K2_W'(node_b);
        c2 = K2_W'(node_c);
        d2 = K2_W'(node_d);
        k3 = d3 - a3 + (b3 <<< 1) + b3 - (c3 <<< 1) - c3;
        k2 = (a2 <<< 1) - (b2 <<< 2) - b2 + (c2 <<< 2) - d2;
        k1 = K1_W'(node_c) - K1_W'(node_a);
    end

    always_comb
    begin
        su4  = signed'({1'b0, s4_u_reg});
        p1   = ACC1_W'(s4_k3_reg) * ACC1_W'(su4);
        acc1 = p1 + (ACC1_W'(s4_k2_reg) <<< F);
    end

    always_comb
    begin
        su5  = signed'({1'b0, s5_u_reg});
        p2   = ACC2_W'(s5_acc1_reg) * ACC2_W'(su5);
        acc2 = p2 + (ACC2_W'(s5_k1_reg) <<< (2 * F));
    end

    always_comb
    begin
        su6  = signed'({1'b0, s6_u_reg});
        hi   = signed'(s6_acc2_reg[ACC2_W-1:F]);
        lo   = s6_acc2_reg[F-1:0];
        p_hi = H_W'(hi) * H_W'(su6);
        p_lo = (2 * F + 1)'(lo) * (2 * F + 1)'(s6_u_reg);
    end

    always_comb
    begin
        h = s7_phi_reg + signed'(H_W'(s7_plo_reg)) + (H_W'(s7_b_reg) <<< (2 * F + 1));
    end

    // ties go up: add half, floor by the shift
    always_comb
    begin
        h_rnd = s8_h_reg + HALF;
        r     = signed'(h_rnd[H_W-1:2*F+1]);
        if (r > R_MAX)
        begin
            r_sat = R_MAX[C-1:0];
        end
        else if (r < R_MIN)
        begin
            r_sat = R_MIN[C-1:0];
        end
        else
        begin
            r_sat = r[C-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s4_k3_reg <= k3;
            s4_k2_reg <= k2;
            s4_k1_reg <= k1;
            s4_b_reg  <= node_b;
            s4_u_reg  <= frac;
        end
        if (load[1])
        begin
            s5_acc1_reg <= acc1;
            s5_k1_reg   <= s4_k1_reg;
            s5_b_reg    <= s4_b_reg;
            s5_u_reg    <= s4_u_reg;
        end
        if (load[2])
        begin
            s6_acc2_reg <= acc2;
            s6_b_reg    <= s5_b_reg;
            s6_u_reg    <= s5_u_reg;
        end
        if (load[3])
        begin
            s7_phi_reg <= p_hi;
            s7_plo_reg <= p_lo[2*F:F];
            s7_b_reg   <= s6_b_reg;
        end
        if (load[4])
        begin
            s8_h_reg <= h;
        end
        if (load[5])
        begin
            s9_point_reg <= r_sat;
        end
    end

    assign point = s9_point_reg;

endmodule

/* rtl/catmull_rom_point_eval.sv */
// catmull_rom_point_eval.sv: top level of the Catmull-Rom point evaluator (uses crpe_pkg).
// An evaluate item passes through stages 1 to 9 in order and leaves from the stage 9 register.
// Throughput: one item per cycle when not stalled; four banks give one read each per cycle.
// A write item updates the table in stage 3 and makes no output transfer.
// Reset clears all stage valid bits and sets node_count to 4; the node table is not cleared.
`include "catmull_rom_point_eval_defines.svh"

module catmull_rom_point_eval
    import crpe_pkg::*;
#(
    parameter int MAX_NODES      = DEF_MAX_NODES,
    parameter int COORD_BITS     = DEF_COORD_BITS,
    parameter int TIME_FRAC_BITS = DEF_TIME_FRAC_BITS,
    localparam int IDX_BITS      = $clog2(MAX_NODES),
    localparam int CNT_BITS      = $clog2(MAX_NODES + 1),
    localparam int IN_BITS       = IDX_BITS + 3 * COORD_BITS + TIME_FRAC_BITS + 1,
    localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W   = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CNT_BITS-1:0]    cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // node_index, node_x, node_y, node_z, curve_time (low to high), zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // point_x, point_y, point_z (low to high), zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int NODE_BITS  = 3 * COORD_BITS;
    localparam int OFS_NODE   = IDX_BITS;
    localparam int OFS_TIME   = OFS_NODE + NODE_BITS;
    localparam int LANE_FIRST = PIPE_STAGES - LANE_STAGES + 1;

    logic [PIPE_STAGES:1]         valid_reg;
    logic [PIPE_STAGES:1]         valid_next;
    logic [PIPE_STAGES:1]         load;

    cmd_t                         s2_cmd;
    logic [IDX_BITS-1:0]          s2_node_index;
    logic [NODE_BITS-1:0]         s2_node;
    logic [IDX_BITS-1:0]          s2_section;
    logic [TIME_FRAC_BITS:0]      s2_frac;
    logic [SPAN*NODE_BITS-1:0]    node_win;
    logic [TIME_FRAC_BITS:0]      s3_frac;
    logic [NODE_BITS-1:0]         point_bus;

    // a stage loads when empty or when the stage after it moves
    always_comb
    begin
        load[PIPE_STAGES] = !valid_reg[PIPE_STAGES] || m_axis_tready;
        for (int i = PIPE_STAGES - 1; i >= 1; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    // write items retire into the table on the way to stage 3
    always_comb
    begin
        for (int i = 1; i <= PIPE_STAGES; i++)
        begin
            if (!load[i])
            begin
                valid_next[i] = valid_reg[i];
            end
            else if (i == 1)
            begin
                valid_next[i] = s_axis_tvalid;
            end
            else if (i == 3)
            begin
                valid_next[i] = valid_reg[2] && (s2_cmd == CMD_EVAL);
            end
            else
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    crpe_front #(
        .MAX_NODES      (MAX_NODES),
        .COORD_BITS     (COORD_BITS),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .load_s1        (load[1]),
        .load_s2        (load[2]),
        .in_cmd         (cmd_t'(s_axis_tuser)),
        .in_node_index  (s_axis_tdata[IDX_BITS-1:0]),
        .in_node        (s_axis_tdata[OFS_NODE +: NODE_BITS]),
        .in_curve_time  (s_axis_tdata[OFS_TIME +: TIME_FRAC_BITS + 1]),
        .s2_cmd         (s2_cmd),
        .s2_node_index  (s2_node_index),
        .s2_node        (s2_node),
        .s2_section     (s2_section),
        .s2_frac        (s2_frac)
    );

    crpe_node_mem #(
        .MAX_NODES      (MAX_NODES),
        .COORD_BITS     (COORD_BITS),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_node_mem (
        .clk            (clk),
        .load           (load[3]),
        .s2_valid       (valid_reg[2]),
        .s2_cmd         (s2_cmd),
        .s2_node_index  (s2_node_index),
        .s2_node        (s2_node),
        .s2_section     (s2_section),
        .s2_frac        (s2_frac),
        .node_win       (node_win),
        .s3_frac        (s3_frac)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        crpe_lane #(
            .COORD_BITS     (COORD_BITS),
            .TIME_FRAC_BITS (TIME_FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .load   (load[PIPE_STAGES:LANE_FIRST]),
            .node_a (node_win[0*NODE_BITS + c*COORD_BITS +: COORD_BITS]),
            .node_b (node_win[1*NODE_BITS + c*COORD_BITS +: COORD_BITS]),
            .node_c (node_win[2*NODE_BITS + c*COORD_BITS +: COORD_BITS]),
            .node_d (node_win[3*NODE_BITS + c*COORD_BITS +: COORD_BITS]),
            .frac   (s3_frac),
            .point  (point_bus[c*COORD_BITS +: COORD_BITS])
        );
    end

    assign s_axis_tready = load[1];
    assign m_axis_tvalid = valid_reg[PIPE_STAGES];
    assign m_axis_tdata  = OUT_TDATA_W'(point_bus);

    `CRPE_ASSERT_COMB(a_full_stall_blocks_input, clk, rst_n, (&valid_reg) && !m_axis_tready, !s_axis_tready, "full pipeline stalled but input still ready")
    `CRPE_ASSERT_COMB(a_empty_accepts, clk, rst_n, valid_reg == '0, s_axis_tready, "empty pipeline refuses a transfer")
    `CRPE_ASSERT_NEXT(a_no_item_created, clk, rst_n, !(s_axis_tvalid && s_axis_tready), $countones(valid_reg) <= $past($countones(valid_reg)), "item count grew without an input transfer")
    `CRPE_ASSERT_NEXT(a_output_drains, clk, rst_n, m_axis_tvalid && m_axis_tready && !(s_axis_tvalid && s_axis_tready), $countones(valid_reg) < $past($countones(valid_reg)), "output transfer did not remove an item")

endmodule
